>>> hdl/dkrn_pkg.sv
// shared types and constants for the delimited key reference numberer
// used by dkrn_cell, dkrn_chain and delimited_key_reference_numberer_core
package dkrn_pkg;

    localparam logic [1:0] KIND_LITERAL  = 2'd0;
    localparam logic [1:0] KIND_EXISTING = 2'd1;
    localparam logic [1:0] KIND_NEW      = 2'd2;
    localparam logic [1:0] KIND_FULL     = 2'd3;

    localparam logic [7:0] DELIM_RESET = 8'd36;

    typedef struct packed {
        logic open;
        logic wr;
        logic rd;
        logic cmp;
        logic commit;
    } ctrl_t;

endpackage

>>> hdl/dkrn_cell.sv
// one table entry: stored key bytes, stored length and a running match flag
// depends on dkrn_pkg
module dkrn_cell #(
    parameter int ENTRIES = 32,
    parameter int KEY_LEN = 64,
    parameter int IDX     = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dkrn_pkg::ctrl_t                     ctrl,
    input  logic [$clog2(ENTRIES+1)-1:0]        cand,
    input  logic [7:0]                          wr_byte,
    input  logic [((KEY_LEN>1)?$clog2(KEY_LEN):1)-1:0] addr,
    input  logic [7:0]                          cmp_byte,
    input  logic [$clog2(KEY_LEN+1)-1:0]        cmp_pos,
    input  logic [$clog2(KEY_LEN+1)-1:0]        key_len,
    input  logic                                found_in,
    input  logic [$clog2(ENTRIES+1)-1:0]        idx_in,
    output logic                                found_out,
    output logic [$clog2(ENTRIES+1)-1:0]        idx_out
);
    localparam int CW = $clog2(ENTRIES+1);
    localparam int LW = $clog2(KEY_LEN+1);
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);
    localparam logic [CW-1:0] MY_REF = CW'(IDX + 1);

    logic [7:0]    mem [KEY_LEN];
    logic [7:0]    rd_reg;
    logic [LW-1:0] len_reg;
    logic          valid_reg;
    logic          match_reg;
    logic          match_next;
    logic          sel;
    logic          hit;

    assign sel = (cand == MY_IDX);

    always_ff @(posedge clk)
    begin
        if (ctrl.wr && sel)
        begin
            mem[addr] <= wr_byte;
        end
        if (ctrl.rd)
        begin
            rd_reg <= mem[addr];
        end
        if (ctrl.commit && sel)
        begin
            len_reg <= key_len;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.open)
        begin
            match_next = 1'b1;
        end
        else if (ctrl.cmp)
        begin
            match_next = match_reg && (rd_reg == cmp_byte) && (cmp_pos < len_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            if (ctrl.commit && sel)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    assign hit       = valid_reg && match_reg && (len_reg == key_len);
    assign found_out = found_in || hit;
    assign idx_out   = found_in ? idx_in : (hit ? MY_REF : '0);

endmodule

>>> hdl/dkrn_chain.sv
// row of entry cells, match result handed from cell to cell
// depends on dkrn_pkg and dkrn_cell
module dkrn_chain #(
    parameter int ENTRIES = 32,
    parameter int KEY_LEN = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dkrn_pkg::ctrl_t                     ctrl,
    input  logic [$clog2(ENTRIES+1)-1:0]        cand,
    input  logic [7:0]                          wr_byte,
    input  logic [((KEY_LEN>1)?$clog2(KEY_LEN):1)-1:0] addr,
    input  logic [7:0]                          cmp_byte,
    input  logic [$clog2(KEY_LEN+1)-1:0]        cmp_pos,
    input  logic [$clog2(KEY_LEN+1)-1:0]        key_len,
    output logic                                found,
    output logic [$clog2(ENTRIES+1)-1:0]        found_ref
);
    localparam int CW = $clog2(ENTRIES+1);

    logic          f   [ENTRIES+1];
    logic [CW-1:0] idx [ENTRIES+1];

    assign f[0]   = 1'b0;
    assign idx[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        dkrn_cell #(
            .ENTRIES (ENTRIES),
            .KEY_LEN (KEY_LEN),
            .IDX     (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .cand      (cand),
            .wr_byte   (wr_byte),
            .addr      (addr),
            .cmp_byte  (cmp_byte),
            .cmp_pos   (cmp_pos),
            .key_len   (key_len),
            .found_in  (f[i]),
            .idx_in    (idx[i]),
            .found_out (f[i+1]),
            .idx_out   (idx[i+1])
        );
    end

    assign found     = f[ENTRIES];
    assign found_ref = idx[ENTRIES];

endmodule

>>> hdl/delimited_key_reference_numberer_core.sv
// delimited key reference numberer top level: input control, entry count, result register
// depends on dkrn_pkg and dkrn_chain
// a literal or close result is registered in the cycle after its input transfer
// a stored key byte is followed by the S_CMP state for the cell memory read and compare,
// in which no input is taken; other bytes and closes go without it
// reset: asynchronous active low, clears key state, entry count, cell valid bits, sets delimiter to DELIM_RESET
module delimited_key_reference_numberer_core #(
    parameter int ENTRIES = 32,
    parameter int KEY_LEN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // delimiter
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // out_byte, ref_number, key_truncated, zero pad
    output logic [1:0]  m_axis_tuser   // kind
);
    localparam int CW = $clog2(ENTRIES+1);
    localparam int AW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
    localparam int LW = $clog2(KEY_LEN+1);
    localparam logic [CW-1:0] ENT_MAX = CW'(ENTRIES);
    localparam logic [LW-1:0] LEN_MAX = LW'(KEY_LEN);

    typedef enum logic {S_IDLE, S_CMP} state_t;

    state_t          state_reg, state_next;
    logic [7:0]      delim_reg;
    logic            inside_reg, inside_next;
    logic [LW-1:0]   klen_reg, klen_next;
    logic            over_reg, over_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [7:0]      byte_d_reg;
    logic [LW-1:0]   pos_d_reg;
    logic            ov_reg, ov_next;
    logic [1:0]      kind_reg, kind_next;
    logic [7:0]      obyte_reg, obyte_next;
    logic [5:0]      oref_reg, oref_next;
    logic            ocut_reg, ocut_next;
    logic            accept;
    logic [7:0]      b;
    dkrn_pkg::ctrl_t ctrl;
    logic            found;
    logic [CW-1:0]   found_ref;
    logic [CW-1:0]   new_ref;

    assign b             = s_axis_tdata;
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE) && (!ov_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign new_ref       = cnt_reg + CW'(1);

    dkrn_chain #(
        .ENTRIES (ENTRIES),
        .KEY_LEN (KEY_LEN)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cand      (cnt_reg),
        .wr_byte   (b),
        .addr      (klen_reg[AW-1:0]),
        .cmp_byte  (byte_d_reg),
        .cmp_pos   (pos_d_reg),
        .key_len   (klen_reg),
        .found     (found),
        .found_ref (found_ref)
    );

    always_comb
    begin
        state_next  = S_IDLE;
        inside_next = inside_reg;
        klen_next   = klen_reg;
        over_next   = over_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg && !m_axis_tready;
        kind_next   = kind_reg;
        obyte_next  = obyte_reg;
        oref_next   = oref_reg;
        ocut_next   = ocut_reg;
        ctrl        = '0;
        ctrl.cmp    = (state_reg == S_CMP);
        if (accept)
        begin
            if (!inside_reg)
            begin
                if (b == delim_reg)
                begin
                    inside_next = 1'b1;
                    klen_next   = '0;
                    over_next   = 1'b0;
                    ctrl.open   = 1'b1;
                end
                else
                begin
                    ov_next    = 1'b1;
                    kind_next  = dkrn_pkg::KIND_LITERAL;
                    obyte_next = b;
                    oref_next  = '0;
                    ocut_next  = 1'b0;
                end
            end
            else if (b != delim_reg)
            begin
                if (klen_reg < LEN_MAX)
                begin
                    ctrl.wr    = 1'b1;
                    ctrl.rd    = 1'b1;
                    klen_next  = klen_reg + LW'(1);
                    state_next = S_CMP;
                end
                else
                begin
                    over_next = 1'b1;
                end
            end
            else
            begin
                inside_next = 1'b0;
                ov_next     = 1'b1;
                obyte_next  = '0;
                ocut_next   = over_reg;
                if (found)
                begin
                    kind_next = dkrn_pkg::KIND_EXISTING;
                    oref_next = 6'(found_ref);
                end
                else if (cnt_reg < ENT_MAX)
                begin
                    ctrl.commit = 1'b1;
                    cnt_next    = new_ref;
                    kind_next   = dkrn_pkg::KIND_NEW;
                    oref_next   = 6'(new_ref);
                end
                else
                begin
                    kind_next = dkrn_pkg::KIND_FULL;
                    oref_next = '0;
                end
                klen_next = '0;
                over_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            delim_reg  <= dkrn_pkg::DELIM_RESET;
            inside_reg <= 1'b0;
            klen_reg   <= '0;
            over_reg   <= 1'b0;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
            byte_d_reg <= '0;
            pos_d_reg  <= '0;
            kind_reg   <= dkrn_pkg::KIND_LITERAL;
            obyte_reg  <= '0;
            oref_reg   <= '0;
            ocut_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            inside_reg <= inside_next;
            klen_reg   <= klen_next;
            over_reg   <= over_next;
            cnt_reg    <= cnt_next;
            ov_reg     <= ov_next;
            if (accept)
            begin
                byte_d_reg <= b;
                pos_d_reg  <= klen_reg;
            end
            kind_reg  <= kind_next;
            obyte_reg <= obyte_next;
            oref_reg  <= oref_next;
            ocut_reg  <= ocut_next;
            if (cfg_valid)
            begin
                delim_reg <= cfg_data;
            end
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {1'b0, ocut_reg, oref_reg, obyte_reg};
    assign m_axis_tuser  = kind_reg;

    a_cmp_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |=> state_reg == S_IDLE)
        else $error("compare state held");

    a_no_accept_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> !s_axis_tready)
        else $error("input taken during compare");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ENT_MAX)
        else $error("entry count overflow");

    a_new_ref: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && kind_reg == dkrn_pkg::KIND_NEW |-> oref_reg == 6'(cnt_reg))
        else $error("new reference does not match entry count");

endmodule

>>> bench/delimited_key_reference_numberer_core_tb.sv
// testbench for delimited_key_reference_numberer_core: drives text bytes and delimiter writes,
// predicts each result from its own key table model and compares field by field
// depends on dkrn_pkg and delimited_key_reference_numberer_core
`timescale 1ns / 100ps

module delimited_key_reference_numberer_core_tb;

    localparam int ENTRIES = 32;
    localparam int KEY_LEN = 64;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [5:0] ref_number;
        logic       key_truncated;
    } token_t;

    typedef struct {
        logic [7:0] in_byte;
        logic       has_known;
        token_t     known;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;  // out_byte, ref_number, key_truncated, zero pad
    logic [1:0]  m_axis_tuser;  // kind

    delimited_key_reference_numberer_core #(.ENTRIES(ENTRIES), .KEY_LEN(KEY_LEN)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    // numberer state copy
    logic [7:0] delim_q;
    logic       in_key;
    logic [7:0] open_key [KEY_LEN];
    int         open_len;
    logic       cut_flag;
    logic [7:0] stored_keys [ENTRIES][KEY_LEN];
    int         stored_lens [ENTRIES];
    int         used_entries;

    token_t expected_tokens [$];
    int     errors = 0;
    int     src_idle_pct = 0;
    int     dst_idle_pct = 0;
    int     hold_off = 0;
    int     quiet_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic bit number_byte(input logic [7:0] b, output token_t tok);
        int hit;
        bit same;
        tok = '0;
        if (!in_key)
        begin
            if (b == delim_q)
            begin
                in_key = 1'b1;
                open_len = 0;
                cut_flag = 1'b0;
                return 1'b0;
            end
            tok.kind = dkrn_pkg::KIND_LITERAL;
            tok.out_byte = b;
            return 1'b1;
        end
        if (b != delim_q)
        begin
            if (open_len < KEY_LEN)
            begin
                open_key[open_len] = b;
                open_len++;
            end
            else
            begin
                cut_flag = 1'b1;
            end
            return 1'b0;
        end
        in_key = 1'b0;
        tok.key_truncated = cut_flag;
        hit = -1;
        for (int e = 0; e < used_entries && hit < 0; e++)
        begin
            if (stored_lens[e] == open_len)
            begin
                same = 1'b1;
                for (int i = 0; i < open_len; i++)
                    if (stored_keys[e][i] != open_key[i])
                        same = 1'b0;
                if (same)
                    hit = e;
            end
        end
        if (hit >= 0)
        begin
            tok.kind = dkrn_pkg::KIND_EXISTING;
            tok.ref_number = 6'(hit + 1);
        end
        else if (used_entries < ENTRIES)
        begin
            for (int i = 0; i < open_len; i++)
                stored_keys[used_entries][i] = open_key[i];
            stored_lens[used_entries] = open_len;
            used_entries++;
            tok.kind = dkrn_pkg::KIND_NEW;
            tok.ref_number = 6'(used_entries);
        end
        else
        begin
            tok.kind = dkrn_pkg::KIND_FULL;
        end
        open_len = 0;
        cut_flag = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        token_t tok;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (number_byte(b, tok))
            expected_tokens.push_back(tok);
        @(negedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_delim(input logic [7:0] d);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        delim_q = d;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_text(input logic [7:0] key, input int len, input bit closed);
        send_byte(delim_q);
        for (int i = 0; i < len; i++)
            send_byte(key + 8'(i % 3));
        if (closed)
            send_byte(delim_q);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == delim_q)
            b = ~b;
        return b;
    endfunction

    // receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= rst_n && ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_tokens.size() == 0)
            begin
                report_mismatch("unexpected result transfer", 1, 0);
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (m_axis_tuser != want.kind)
                    report_mismatch("kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[7:0] != want.out_byte)
                    report_mismatch("out_byte", m_axis_tdata[7:0], want.out_byte);
                if (m_axis_tdata[13:8] != want.ref_number)
                    report_mismatch("ref_number", m_axis_tdata[13:8], want.ref_number);
                if (m_axis_tdata[14] != want.key_truncated)
                    report_mismatch("key_truncated", m_axis_tdata[14], want.key_truncated);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic stim_row_t lit(input logic [7:0] b);
        stim_row_t r;
        r.in_byte = b;
        r.has_known = 1'b1;
        r.known = '{dkrn_pkg::KIND_LITERAL, b, 6'd0, 1'b0};
        return r;
    endfunction

    function automatic stim_row_t quiet(input logic [7:0] b);
        stim_row_t r;
        r.in_byte = b;
        r.has_known = 1'b0;
        r.known = '0;
        return r;
    endfunction

    initial
    begin
        stim_row_t rows [$];
        token_t tok;
        bit got;
        delim_q = dkrn_pkg::DELIM_RESET;
        in_key = 1'b0;
        open_len = 0;
        cut_flag = 1'b0;
        used_entries = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // literals at the extremes, empty key, short keys, repeat
        rows = '{lit(8'h00), lit(8'hFF), lit(8'h55), lit(8'hAA),
                 quiet(dkrn_pkg::DELIM_RESET), quiet(dkrn_pkg::DELIM_RESET),
                 quiet(dkrn_pkg::DELIM_RESET), quiet(8'h41), quiet(dkrn_pkg::DELIM_RESET),
                 quiet(dkrn_pkg::DELIM_RESET), quiet(8'h41), quiet(dkrn_pkg::DELIM_RESET),
                 quiet(dkrn_pkg::DELIM_RESET), quiet(dkrn_pkg::DELIM_RESET), lit(8'h0A)};
        foreach (rows[i])
        begin
            got = 1'b0;
            if (rows[i].has_known)
            begin
                tok = rows[i].known;
                got = 1'b1;
            end
            send_byte(rows[i].in_byte);
            if (got && expected_tokens.size() != 0
                    && expected_tokens[$] != tok)
                report_mismatch("directed row", i, i);
        end
        send_text(8'h30, KEY_LEN, 1'b1);
        send_text(8'h30, KEY_LEN + 5, 1'b1);
        write_delim(8'h00);
        send_text(8'h80, 2, 1'b1);
        send_byte(8'h00);
        send_byte(8'h00);
        write_delim(8'hFF);
        send_text(8'h01, 1, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 50 : 0;
            dst_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 14 : 0;
            write_delim(phase == 2 ? dkrn_pkg::DELIM_RESET : 8'($urandom_range(255)));
            if (phase == 1)
                hold_off <= 300;
            for (int n = 0; n < 62; n++)
            begin
                case ($urandom_range(9))
                    0, 1, 2: send_byte(plain_byte());
                    3: send_byte(8'($urandom_range(255)));
                    4: send_text(8'($urandom_range(255)), $urandom_range(KEY_LEN + 8), 1'b1);
                    default: send_text(8'($urandom_range(3) * 64), $urandom_range(3), 1'b1);
                endcase
            end
            if (in_key)
                send_byte(delim_q);
            drain();
        end

        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
